FILE: hw/rtl/adif_tvp_pkg.sv
package adif_tvp_pkg;

	localparam int LENGTH_BITS = 16;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_GT    = 8'h3E;

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef enum logic [2:0] {
		PH_SEEK  = 3'd0,
		PH_NAME  = 3'd1,
		PH_LEN   = 3'd2,
		PH_TYPE  = 3'd3,
		PH_VALUE = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       input_last;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_out;
		logic       field_done;
	} result_t;

	typedef struct packed {
		phase_t                 phase;
		logic [LENGTH_BITS-1:0] len_acc;
		logic                   len_bad;
		logic [LENGTH_BITS-1:0] remain;
	} parse_state_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

FILE: hw/rtl/adif_tvp_step.sv
module adif_tvp_step (
	input  adif_tvp_pkg::parse_state_t st,
	input  adif_tvp_pkg::item_t        item,
	output adif_tvp_pkg::parse_state_t st_nxt,
	output logic                       res_vld,
	output adif_tvp_pkg::result_t      res
);
	import adif_tvp_pkg::*;

	logic [7:0]             c;
	logic                   sp;
	logic [LENGTH_BITS+3:0] acc_next;
	logic                   acc_ovf;
	logic [LENGTH_BITS-1:0] len_eff;
	logic [LENGTH_BITS-1:0] remain_dec;

	assign c  = item.char_in;
	assign sp = is_space(c);

	// acc * 10 + digit, with headroom to spot overflow
	assign acc_next = ({4'b0000, st.len_acc} << 3) + ({4'b0000, st.len_acc} << 1)
		+ {{LENGTH_BITS{1'b0}}, c[3:0]};
	assign acc_ovf    = |acc_next[LENGTH_BITS+3:LENGTH_BITS];
	assign len_eff    = st.len_bad ? '0 : st.len_acc;
	assign remain_dec = st.remain - 1'b1;

	// next state
	always_comb begin
		st_nxt = st;
		unique case (st.phase)
			PH_SEEK: begin
				if (c == CH_LT) begin
					st_nxt.phase   = PH_NAME;
					st_nxt.len_acc = '0;
					st_nxt.len_bad = 1'b0;
					st_nxt.remain  = '0;
				end
			end
			PH_NAME: begin
				if (!sp) begin
					if (c == CH_COLON) begin
						st_nxt.phase = PH_LEN;
					end else if (c == CH_GT) begin
						st_nxt.phase = PH_SEEK;
					end
				end
			end
			PH_LEN: begin
				if (!sp) begin
					if (c == CH_COLON) begin
						st_nxt.phase = PH_TYPE;
					end else if (c == CH_GT) begin
						if (len_eff != '0) begin
							st_nxt.remain = len_eff;
							st_nxt.phase  = PH_VALUE;
						end else begin
							st_nxt.phase = PH_SEEK;
						end
					end else if (is_digit(c)) begin
						if (!st.len_bad) begin
							if (acc_ovf) begin
								st_nxt.len_bad = 1'b1;
								st_nxt.len_acc = '0;
							end else begin
								st_nxt.len_acc = acc_next[LENGTH_BITS-1:0];
							end
						end
					end else begin
						st_nxt.len_bad = 1'b1;
					end
				end
			end
			PH_TYPE: begin
				if (c == CH_GT) begin
					if (len_eff != '0) begin
						st_nxt.remain = len_eff;
						st_nxt.phase  = PH_VALUE;
					end else begin
						st_nxt.phase = PH_SEEK;
					end
				end
			end
			PH_VALUE: begin
				st_nxt.remain = remain_dec;
				if (remain_dec == '0) begin
					st_nxt.phase = PH_SEEK;
				end
			end
			default: begin
				st_nxt.phase = PH_SEEK;
			end
		endcase
		// drop any open tag or value at end of stream
		if (item.input_last) begin
			st_nxt.phase   = PH_SEEK;
			st_nxt.len_acc = '0;
			st_nxt.len_bad = 1'b0;
			st_nxt.remain  = '0;
		end
	end

	// result
	always_comb begin
		res_vld        = 1'b0;
		res.kind       = KIND_END;
		res.char_out   = '0;
		res.field_done = 1'b1;
		unique case (st.phase)
			PH_NAME: begin
				if (!sp && c != CH_COLON) begin
					res_vld = 1'b1;
					if (c != CH_GT) begin
						res.kind       = KIND_NAME;
						res.char_out   = to_lower(c);
						res.field_done = 1'b0;
					end
				end
			end
			PH_LEN: begin
				res_vld = !sp && c == CH_GT && len_eff == '0;
			end
			PH_TYPE: begin
				res_vld = c == CH_GT && len_eff == '0;
			end
			PH_VALUE: begin
				res_vld        = 1'b1;
				res.kind       = KIND_VALUE;
				res.char_out   = c;
				res.field_done = remain_dec == '0;
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/adif_tag_value_parser_unit.sv
// ADIF tag parser: takes one byte of the text stream per clock unless stalled and emits
// lower-cased name bytes, raw value bytes and end-of-field marks for tags written
// <name:length:type>value. Throughput is one byte per cycle while in_stall is low; a byte's
// result, if it has one, is shown the cycle after the byte is taken when the output queue is
// empty. Parse state sits in one register set updated by a single step of logic, and results
// go into a two-entry output queue, so input keeps flowing while one result waits; in_stall is
// high whenever two results are queued, whether or not the output takes one in that cycle.
module adif_tag_value_parser_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  adif_tvp_pkg::item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output adif_tvp_pkg::result_t out_data
);
	import adif_tvp_pkg::*;

	parse_state_t st_q;
	parse_state_t st_nxt;
	logic         res_vld;
	result_t      res;

	result_t      fifo_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	logic         in_acc;
	logic         push;
	logic         pop;

	adif_tvp_step u_step (
		.st      (st_q),
		.item    (in_data),
		.st_nxt  (st_nxt),
		.res_vld (res_vld),
		.res     (res)
	);

	assign in_stall  = cnt_q == 2'd2;
	assign in_acc    = in_valid && !in_stall;
	assign push      = in_acc && res_vld;
	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase   <= PH_SEEK;
			st_q.len_acc <= '0;
			st_q.len_bad <= 1'b0;
			st_q.remain  <= '0;
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	a_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_VALUE |-> st_q.remain != '0)
		else $error("value phase with no bytes remaining");

	a_name_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.kind == KIND_NAME && out_data.field_done))
		else $error("name byte flagged as field end");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.input_last |=> st_q.phase == PH_SEEK && st_q.remain == '0)
		else $error("end of stream did not return to seek");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue overflow");

endmodule

FILE: tb/tb_adif_tag_value_parser_unit.sv
module tb_adif_tag_value_parser_unit;
	import adif_tvp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] DIGIT_0 = 8'h30;
	localparam logic [7:0] DIGIT_9 = 8'h39;
	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef struct {
		item_t item;
		bit    wait_idle;
	} stim_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	item_t   in_data = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	result_t out_data;

	adif_tag_value_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stim_t       pending[$];
	result_t     expected_results[$];
	logic [7:0]  tag_bytes[$];

	// parser state as predicted
	phase_t                 ps_phase;
	logic [LENGTH_BITS-1:0] ps_len_acc;
	logic                   ps_len_bad;
	logic [LENGTH_BITS-1:0] ps_remain;

	int unsigned cycle_count = 0;
	int unsigned n_fail = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_name = 0;
	int unsigned n_value = 0;
	int unsigned n_end = 0;
	int unsigned n_abandoned = 0;
	int unsigned send_gap = 0;
	int unsigned send_burst = 0;
	int unsigned stall_left = 0;
	int unsigned stall_burst = 0;
	int unsigned hold_left = 0;
	result_t     got;
	result_t     want;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic int unsigned draw_wait(inout int unsigned burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	// random byte that is not whitespace and not one of the two given delimiters
	function automatic logic [7:0] draw_filler(input logic [7:0] avoid_a, input logic [7:0] avoid_b);
		logic [7:0] c;
		do begin
			case ($urandom_range(0, 2))
			0: c = UPPER_A + 8'($urandom_range(0, 25));
			1: c = UPPER_A + CASE_GAP + 8'($urandom_range(0, 25));
			default: c = 8'($urandom_range(0, 255));
			endcase
		end while (c == avoid_a || c == avoid_b || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
		return c;
	endfunction

	task automatic maybe_space();
		int unsigned k;
		if ($urandom_range(0, 9) == 0) begin
			k = $urandom_range(0, 5);
			tag_bytes.push_back(k == 0 ? CH_SPACE : CH_TAB + 8'(k - 1));
		end
	endtask

	task automatic push_byte(input logic [7:0] c, input logic fin);
		stim_t s;
		s.item.char_in = c;
		s.item.input_last = fin;
		s.wait_idle = 1'b0;
		pending.push_back(s);
	endtask

	task automatic push_text(input string s);
		int unsigned i;
		for (i = 0; i < s.len(); i++) begin
			push_byte(s[i], 1'b0);
		end
	endtask

	// one tag, mostly well formed, sometimes noise or cut short by the last-byte flag
	task automatic add_random_segment();
		int unsigned r;
		int unsigned n;
		int unsigned i;
		int unsigned cut;
		int unsigned nlen;
		bit          bad;
		bit          must_end;
		logic        fin;
		string       digits;
		bad = 0;
		must_end = 0;
		nlen = 0;
		digits = "";
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 5);
			repeat (n) tag_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) tag_bytes.push_back(draw_filler(CH_LT, CH_LT));
			tag_bytes.push_back(CH_LT);
			n = $urandom_range(1, 6);
			repeat (n) begin
				maybe_space();
				tag_bytes.push_back(draw_filler(CH_COLON, CH_GT));
			end
			r = $urandom_range(0, 99);
			if (r < 5) begin
				tag_bytes.push_back(CH_GT);
			end else begin
				tag_bytes.push_back(CH_COLON);
				if (r < 58) begin
					nlen = $urandom_range(1, 8);
					digits = $sformatf("%0d", nlen);
				end else if (r < 63) begin
					digits = "0";
				end else if (r < 68) begin
					digits = "";
				end else if (r < 76) begin
					digits = $sformatf("%0d", $urandom_range(1, 99));
					bad = 1;
				end else if (r < 84) begin
					digits = $sformatf("%0d", $urandom_range(65536, 999999));
				end else if (r < 88) begin
					// largest legal length: stream ends a few bytes into the value
					digits = "65535";
					nlen = $urandom_range(1, 6);
					must_end = 1;
				end else begin
					nlen = $urandom_range(1, 4);
					digits = $sformatf("000%0d", nlen);
				end
				for (i = 0; i < digits.len(); i++) begin
					maybe_space();
					tag_bytes.push_back(digits[i]);
				end
				if (bad) begin
					tag_bytes.push_back(draw_filler(CH_COLON, CH_GT));
					if (tag_bytes[tag_bytes.size() - 1] inside {[DIGIT_0:DIGIT_9]})
						tag_bytes[tag_bytes.size() - 1] = UPPER_A;
				end
				if ($urandom_range(0, 1)) begin
					tag_bytes.push_back(CH_COLON);
					n = $urandom_range(0, 3);
					repeat (n) begin
						maybe_space();
						tag_bytes.push_back(draw_filler(CH_GT, CH_GT));
					end
				end
				tag_bytes.push_back(CH_GT);
				repeat (nlen) tag_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		cut = tag_bytes.size() - 1;
		fin = 1'b0;
		if (must_end || $urandom_range(0, 99) < 12) begin
			if (!must_end)
				cut = $urandom_range(0, tag_bytes.size() - 1);
			fin = 1'b1;
		end else if ($urandom_range(0, 99) < 3) begin
			fin = 1'b1;
		end
		for (i = 0; i <= cut; i++) begin
			push_byte(tag_bytes[i], fin && i == cut);
		end
		tag_bytes.delete();
	endtask

	// advance the predicted parser by one byte and queue the result it causes
	task automatic parse_byte(input item_t it);
		logic [7:0]      c;
		logic            ws;
		logic            closing;
		logic            has_res;
		longint unsigned acc_next;
		result_t         res;
		c = it.char_in;
		ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		closing = 1'b0;
		has_res = 1'b0;
		res = '0;
		case (ps_phase)
		PH_NAME: begin
			if (!ws) begin
				if (c == CH_COLON) begin
					ps_phase = PH_LEN;
				end else if (c == CH_GT) begin
					ps_phase = PH_SEEK;
					res.kind = KIND_END;
					res.field_done = 1'b1;
					has_res = 1'b1;
				end else begin
					res.kind = KIND_NAME;
					res.char_out = (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_GAP : c;
					has_res = 1'b1;
				end
			end
		end
		PH_LEN: begin
			if (!ws) begin
				if (c == CH_COLON) begin
					ps_phase = PH_TYPE;
				end else if (c == CH_GT) begin
					closing = 1'b1;
				end else if (c >= DIGIT_0 && c <= DIGIT_9) begin
					if (!ps_len_bad) begin
						acc_next = ps_len_acc;
						acc_next = acc_next * 10 + (c - DIGIT_0);
						if (acc_next > LEN_MAX) begin
							ps_len_bad = 1'b1;
							ps_len_acc = '0;
						end else begin
							ps_len_acc = acc_next[LENGTH_BITS-1:0];
						end
					end
				end else begin
					ps_len_bad = 1'b1;
				end
			end
		end
		PH_TYPE: begin
			if (c == CH_GT)
				closing = 1'b1;
		end
		PH_VALUE: begin
			ps_remain = ps_remain - 1'b1;
			res.kind = KIND_VALUE;
			res.char_out = c;
			res.field_done = (ps_remain == 0);
			has_res = 1'b1;
			if (ps_remain == 0)
				ps_phase = PH_SEEK;
		end
		default: begin
			ps_phase = PH_SEEK;
			if (c == CH_LT) begin
				ps_phase = PH_NAME;
				ps_len_acc = '0;
				ps_len_bad = 1'b0;
				ps_remain = '0;
			end
		end
		endcase
		if (closing) begin
			if (!ps_len_bad && ps_len_acc != 0) begin
				ps_remain = ps_len_acc;
				ps_phase = PH_VALUE;
			end else begin
				ps_phase = PH_SEEK;
				res.kind = KIND_END;
				res.field_done = 1'b1;
				has_res = 1'b1;
			end
		end
		if (it.input_last) begin
			if (ps_phase != PH_SEEK)
				n_abandoned++;
			ps_phase = PH_SEEK;
			ps_len_acc = '0;
			ps_len_bad = 1'b0;
			ps_remain = '0;
		end
		if (has_res)
			expected_results.push_back(res);
	endtask

	// driver: offer queued transactions, predict each one that is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
			ps_phase = PH_SEEK;
			ps_len_acc = '0;
			ps_len_bad = 1'b0;
			ps_remain = '0;
		end else begin
			if (in_valid && !in_stall) begin
				parse_byte(in_data);
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0 &&
						(!pending[0].wait_idle || expected_results.size() == 0)) begin
					in_data <= pending[0].item;
					in_valid <= 1'b1;
					void'(pending.pop_front());
					send_gap = draw_wait(send_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transaction, drive the output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = out_data;
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d char_out %02h field_done %0b",
						got.kind, got.char_out, got.field_done);
					n_fail++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						n_fail++;
					end
					if (got.char_out !== want.char_out) begin
						$error("char_out: expected %02h, got %02h", want.char_out, got.char_out);
						n_fail++;
					end
					if (got.field_done !== want.field_done) begin
						$error("field_done: expected %0b, got %0b",
							want.field_done, got.field_done);
						n_fail++;
					end
					case (want.kind)
					KIND_NAME: n_name++;
					KIND_VALUE: n_value++;
					default: n_end++;
					endcase
				end
				n_checked++;
				stall_left = draw_wait(stall_burst);
				// hold off long enough for the output queue to fill and back up the input
				if (n_checked == 150 || n_checked == 420)
					hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		push_byte(8'hFF, 1'b0);
		push_text("<A Z:\t2:x>");
		push_byte(CH_COLON, 1'b0);
		push_byte(8'h00, 1'b0);
		push_text("<q>");
		push_text("<n:>");
		push_text("<b:x>");
		while (pending.size() < RANDOM_ITEMS + 26)
			add_random_segment();
		// drain the block completely before these transactions
		pending[300].wait_idle = 1'b1;
		pending[650].wait_idle = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d bytes parsed: %0d name bytes, %0d value bytes, %0d bare field ends",
			n_accepted, n_name, n_value, n_end);
		$display("%0d results checked, %0d open tags abandoned by the last-byte flag",
			n_checked, n_abandoned);
		if (n_fail == 0) begin
			$display("adif_tag_value_parser_unit: match");
		end else begin
			$display("adif_tag_value_parser_unit: mismatch");
		end
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("adif_tag_value_parser_unit: mismatch");
		$finish;
	end

endmodule

FILE: adif_tag_value_parser_unit.f
hw/rtl/adif_tvp_pkg.sv
hw/rtl/adif_tvp_step.sv
hw/rtl/adif_tag_value_parser_unit.sv
tb/tb_adif_tag_value_parser_unit.sv
